>>> rtl/core/bmhq_pkg.sv
// Shared types, widths and codes for the binary min-heap queue.
// Used by the channel interfaces, the heap engine and the top level.
`default_nettype none

package bmhq_pkg;

    localparam int HEAP_DEPTH = 256;
    localparam int ADDR_BITS  = $clog2(HEAP_DEPTH);
    localparam int CNT_BITS   = $clog2(HEAP_DEPTH + 1);
    localparam int IDX_BITS   = CNT_BITS + 1;
    localparam int PRIO_BITS  = 32;
    localparam int TAG_BITS   = 16;
    localparam int ENTRY_BITS = PRIO_BITS + TAG_BITS;

    typedef logic [1:0]                  req_code_t;
    typedef logic [1:0]                  status_t;
    typedef logic signed [PRIO_BITS-1:0] prio_t;
    typedef logic [TAG_BITS-1:0]         tag_t;
    typedef logic [ADDR_BITS-1:0]        addr_t;
    typedef logic [CNT_BITS-1:0]         cnt_t;
    typedef logic [IDX_BITS-1:0]         idx_t;

    localparam req_code_t REQ_ENQ = 2'd0;
    localparam req_code_t REQ_DEQ = 2'd1;
    localparam req_code_t REQ_CLR = 2'd2;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    typedef struct packed {
        prio_t prio;
        tag_t  tag;
    } entry_t;

    // top level to engine
    typedef struct packed {
        logic      start;
        req_code_t req_type;
        prio_t     prio;
        tag_t      tag;
        logic      out_free;
    } eng_cmd_t;

    // engine to top level
    typedef struct packed {
        logic idle;
        logic done;
    } eng_stat_t;

    typedef struct packed {
        logic    out_valid;
        prio_t   out_priority;
        tag_t    out_tag;
        logic    head_valid;
        prio_t   head_priority;
        tag_t    head_tag;
        cnt_t    entry_count;
        status_t status;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/bmhq_req_if.sv
// Request channel of the heap queue: valid/ready plus the request fields.
// Depends on bmhq_pkg for field types.
`default_nettype none

interface bmhq_req_if;
    logic                valid;
    logic                ready;
    bmhq_pkg::req_code_t req_type;
    bmhq_pkg::prio_t     in_priority;
    bmhq_pkg::tag_t      in_tag;

    modport source (output valid, output req_type, output in_priority, output in_tag,
                    input ready);
    modport sink   (input valid, input req_type, input in_priority, input in_tag,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/bmhq_rsp_if.sv
// Result channel of the heap queue: valid/ready plus the result fields.
// Depends on bmhq_pkg for field types.
`default_nettype none

interface bmhq_rsp_if;
    logic              valid;
    logic              ready;
    logic              out_valid;
    bmhq_pkg::prio_t   out_priority;
    bmhq_pkg::tag_t    out_tag;
    logic              head_valid;
    bmhq_pkg::prio_t   head_priority;
    bmhq_pkg::tag_t    head_tag;
    bmhq_pkg::cnt_t    entry_count;
    bmhq_pkg::status_t status;

    modport source (output valid, output out_valid, output out_priority, output out_tag,
                    output head_valid, output head_priority, output head_tag,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input out_valid, input out_priority, input out_tag,
                    input head_valid, input head_priority, input head_tag,
                    input entry_count, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/bmhq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bmhq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/bmhq_cmp.sv
// Shared signed priority comparator used by every sift step.
// Depends on bmhq_pkg for the priority type.
`default_nettype none

module bmhq_cmp (
    input  wire bmhq_pkg::prio_t a,
    input  wire bmhq_pkg::prio_t b,
    output logic                 lt
);

    assign lt = (a < b);

endmodule

`default_nettype wire

>>> rtl/core/bmhq_engine.sv
// Heap sequencer: sift-up and sift-down over the heap RAM with one comparator.
// Depends on bmhq_pkg, bmhq_ram and bmhq_cmp.
`default_nettype none

module bmhq_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bmhq_pkg::eng_cmd_t cmd,
    output bmhq_pkg::eng_stat_t     stat,
    output bmhq_pkg::result_t       res
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UP_RD  = 4'd1;
    localparam logic [3:0] S_UP_CMP = 4'd2;
    localparam logic [3:0] S_DQ_R0  = 4'd3;
    localparam logic [3:0] S_DQ_RL  = 4'd4;
    localparam logic [3:0] S_DQ_LD  = 4'd5;
    localparam logic [3:0] S_DN_RL  = 4'd6;
    localparam logic [3:0] S_DN_RR  = 4'd7;
    localparam logic [3:0] S_DN_SEL = 4'd8;
    localparam logic [3:0] S_DN_CMP = 4'd9;
    localparam logic [3:0] S_FINAL  = 4'd10;
    localparam logic [3:0] S_HD_RD  = 4'd11;
    localparam logic [3:0] S_HD     = 4'd12;

    logic [3:0]        state_reg, state_next;
    bmhq_pkg::entry_t  cur_reg, cur_next;
    bmhq_pkg::entry_t  kid_reg, kid_next;
    bmhq_pkg::entry_t  deq_reg, deq_next;
    bmhq_pkg::addr_t   pos_reg, pos_next;
    bmhq_pkg::addr_t   kid_idx_reg, kid_idx_next;
    bmhq_pkg::cnt_t    count_reg, count_next;
    logic              deq_valid_reg, deq_valid_next;
    bmhq_pkg::status_t status_reg, status_next;

    logic                               ram_we;
    bmhq_pkg::addr_t                    ram_waddr;
    bmhq_pkg::entry_t                   ram_wdata;
    bmhq_pkg::addr_t                    ram_raddr;
    logic [bmhq_pkg::ENTRY_BITS-1:0]    ram_rdata;
    bmhq_pkg::entry_t                   rd_entry;

    bmhq_pkg::prio_t cmp_a, cmp_b;
    logic            cmp_lt;

    bmhq_pkg::addr_t parent;
    bmhq_pkg::idx_t  lc_idx, rc_idx, count_ext;

    bmhq_ram #(
        .WIDTH (bmhq_pkg::ENTRY_BITS),
        .DEPTH (bmhq_pkg::HEAP_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bmhq_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .lt (cmp_lt)
    );

    assign rd_entry  = bmhq_pkg::entry_t'(ram_rdata);
    assign parent    = bmhq_pkg::addr_t'(pos_reg - bmhq_pkg::addr_t'(1)) >> 1;
    assign lc_idx    = {1'b0, pos_reg, 1'b1};
    assign rc_idx    = lc_idx + bmhq_pkg::idx_t'(1);
    assign count_ext = {1'b0, count_reg};

    // steer the shared comparator by sequencer step
    always_comb
    begin
        cmp_a = cur_reg.prio;
        cmp_b = kid_reg.prio;
        case (state_reg)
            S_UP_CMP:
            begin
                cmp_a = cur_reg.prio;
                cmp_b = rd_entry.prio;
            end
            S_DN_SEL:
            begin
                cmp_a = kid_reg.prio;
                cmp_b = rd_entry.prio;
            end
            default:
            begin
                cmp_a = cur_reg.prio;
                cmp_b = kid_reg.prio;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        kid_next       = kid_reg;
        deq_next       = deq_reg;
        pos_next       = pos_reg;
        kid_idx_next   = kid_idx_reg;
        count_next     = count_reg;
        deq_valid_next = deq_valid_reg;
        status_next    = status_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = cur_reg;
        ram_raddr      = '0;
        stat.idle      = 1'b0;
        stat.done      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                stat.idle = 1'b1;
                if (cmd.start)
                begin
                    status_next    = bmhq_pkg::ST_OK;
                    deq_valid_next = 1'b0;
                    state_next     = S_HD_RD;
                    unique case (cmd.req_type)
                        bmhq_pkg::REQ_ENQ:
                        begin
                            if (count_reg == bmhq_pkg::cnt_t'(bmhq_pkg::HEAP_DEPTH))
                            begin
                                status_next = bmhq_pkg::ST_FULL;
                            end
                            else
                            begin
                                cur_next   = '{prio: cmd.prio, tag: cmd.tag};
                                pos_next   = count_reg[bmhq_pkg::ADDR_BITS-1:0];
                                count_next = count_reg + bmhq_pkg::cnt_t'(1);
                                state_next = (count_reg == '0) ? S_FINAL : S_UP_RD;
                            end
                        end
                        bmhq_pkg::REQ_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = bmhq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DQ_R0;
                            end
                        end
                        bmhq_pkg::REQ_CLR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = S_HD_RD;
                        end
                    endcase
                end
            end
            S_UP_RD:
            begin
                ram_raddr  = parent;
                state_next = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                ram_raddr = parent;
                if (cmp_lt)
                begin
                    // move parent down into the hole
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg;
                    ram_wdata  = rd_entry;
                    pos_next   = parent;
                    state_next = (parent == '0) ? S_FINAL : S_UP_RD;
                end
                else
                begin
                    state_next = S_FINAL;
                end
            end
            S_DQ_R0:
            begin
                ram_raddr  = '0;
                state_next = S_DQ_RL;
            end
            S_DQ_RL:
            begin
                deq_next       = rd_entry;
                deq_valid_next = 1'b1;
                ram_raddr      = bmhq_pkg::addr_t'(count_reg - bmhq_pkg::cnt_t'(1));
                state_next     = S_DQ_LD;
            end
            S_DQ_LD:
            begin
                cur_next   = rd_entry;
                count_next = count_reg - bmhq_pkg::cnt_t'(1);
                pos_next   = '0;
                state_next = S_DN_RL;
            end
            S_DN_RL:
            begin
                if (lc_idx >= count_ext)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    ram_raddr  = lc_idx[bmhq_pkg::ADDR_BITS-1:0];
                    state_next = S_DN_RR;
                end
            end
            S_DN_RR:
            begin
                kid_next     = rd_entry;
                kid_idx_next = lc_idx[bmhq_pkg::ADDR_BITS-1:0];
                if (rc_idx < count_ext)
                begin
                    ram_raddr  = rc_idx[bmhq_pkg::ADDR_BITS-1:0];
                    state_next = S_DN_SEL;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_SEL:
            begin
                // on a tie take the right child
                if (!cmp_lt)
                begin
                    kid_next     = rd_entry;
                    kid_idx_next = rc_idx[bmhq_pkg::ADDR_BITS-1:0];
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                if (cmp_lt)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg;
                    ram_wdata  = kid_reg;
                    pos_next   = kid_idx_reg;
                    state_next = S_DN_RL;
                end
            end
            S_FINAL:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = cur_reg;
                state_next = S_HD_RD;
            end
            S_HD_RD:
            begin
                ram_raddr  = '0;
                state_next = S_HD;
            end
            S_HD:
            begin
                // hold the root read until the output register frees up
                ram_raddr = '0;
                if (cmd.out_free)
                begin
                    stat.done  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.out_valid     = deq_valid_reg;
        res.out_priority  = deq_valid_reg ? deq_reg.prio : '0;
        res.out_tag       = deq_valid_reg ? deq_reg.tag : '0;
        res.head_valid    = (count_reg != '0);
        res.head_priority = (count_reg != '0) ? rd_entry.prio : '0;
        res.head_tag      = (count_reg != '0) ? rd_entry.tag : '0;
        res.entry_count   = count_reg;
        res.status        = status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            deq_valid_reg <= 1'b0;
            status_reg    <= bmhq_pkg::ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            deq_valid_reg <= deq_valid_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        kid_reg     <= kid_next;
        deq_reg     <= deq_next;
        pos_reg     <= pos_next;
        kid_idx_reg <= kid_idx_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/binary_min_heap_queue_top.sv
// Binary min-heap priority queue of (priority, tag) entries, 256 deep.
//
// Channels: request (sink) carries req_type (enqueue, dequeue, clear),
// in_priority (signed) and in_tag. Result (source) returns one item per
// request: the dequeued entry if any, the head entry and count after the
// operation, and a status (ok, dequeue on empty, enqueue on full).
// Smaller priority is served first; ties on dequeue resolve right-child first.
//
// Clear, no-op and refused requests only read back the head; an enqueue
// sifts up one parent at a time and a dequeue fetches the root and the last
// entry, then sifts down one child level at a time. The pace is set by the
// single read port of the heap RAM, through which the sequencer fetches each
// parent or child in turn, and by the one shared comparator. One request is
// in work at a time; ready is high only while the sequencer is idle, and the
// next request is taken once the sequencer is back in idle after the previous
// result is loaded, so requests do not overlap.
//
// Reset empties the heap at once (count to zero); the RAM needs no clearing.
// A result waits in an output register while the receiver stalls; the next
// request may be taken meanwhile, but its own result holds until the
// register frees up.
`default_nettype none

module binary_min_heap_queue_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bmhq_req_if.sink    request,
    bmhq_rsp_if.source  result
);

    bmhq_pkg::eng_cmd_t  cmd;
    bmhq_pkg::eng_stat_t stat;
    bmhq_pkg::result_t   eng_res;

    logic              rsp_valid_reg, rsp_valid_next;
    bmhq_pkg::result_t rsp_reg;

    assign request.ready = stat.idle;

    always_comb
    begin
        cmd.start    = request.valid && stat.idle;
        cmd.req_type = request.req_type;
        cmd.prio     = request.in_priority;
        cmd.tag      = request.in_tag;
        cmd.out_free = !rsp_valid_reg || result.ready;
    end

    bmhq_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .res   (eng_res)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (stat.done)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // load the result payload on completion
    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            rsp_reg <= eng_res;
        end
    end

    assign result.valid         = rsp_valid_reg;
    assign result.out_valid     = rsp_reg.out_valid;
    assign result.out_priority  = rsp_reg.out_priority;
    assign result.out_tag       = rsp_reg.out_tag;
    assign result.head_valid    = rsp_reg.head_valid;
    assign result.head_priority = rsp_reg.head_priority;
    assign result.head_tag      = rsp_reg.head_tag;
    assign result.entry_count   = rsp_reg.entry_count;
    assign result.status        = rsp_reg.status;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> rsp_reg.entry_count <= bmhq_pkg::cnt_t'(bmhq_pkg::HEAP_DEPTH))
        else $error("entry count above heap depth");

    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> rsp_reg.head_valid == (rsp_reg.entry_count != '0))
        else $error("head valid disagrees with entry count");

    a_deq_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.out_valid) |-> rsp_reg.status == bmhq_pkg::ST_OK)
        else $error("dequeued entry reported with error status");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> !request.ready)
        else $error("sequencer still idle after taking a request");

endmodule

`default_nettype wire
